// ===== rtl/core/ecc_pkg.sv =====
package ecc_pkg;

	localparam int ROW_W            = 32;
	localparam int VC_W             = 6;
	localparam int SV_W             = 5;
	localparam int CFG_IDX_W        = 1;
	localparam int CFG_DATA_W       = 6;
	localparam int MAX_VERTICES_DEF = 32;

	localparam logic [CFG_IDX_W-1:0] REG_VERTEX_COUNT = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_START_VERTEX = 1'b1;

	localparam logic [VC_W-1:0] VERTEX_COUNT_RST = 6'd32;
	localparam logic [SV_W-1:0] START_VERTEX_RST = 5'd0;

	localparam logic [1:0] VERDICT_NONE     = 2'd0;
	localparam logic [1:0] VERDICT_CIRCUIT  = 2'd1;
	localparam logic [1:0] VERDICT_ISOLATED = 2'd2;

	typedef struct packed {
		logic clear;
		logic rewind;
		logic rd_row;
		logic seed;
		logic deg_update;
		logic reach_load;
		logic expand_rd;
		logic reach_or;
		logic close_comp;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		logic i_end;
		logic odd;
		logic pending_none;
		logic out_free;
	} status_t;

endpackage

// ===== rtl/core/eulerian_circuit_check_core.sv =====
// Rows are taken one word per cycle while the block is idle; non-last rows give no word.
// After the last row a degree pass reads every row; unless a degree is odd, a pass
// per vertex i then reads row i and the row of each vertex reached from i in turn.
// The verdict is loaded once the output register is free; all reads use one RAM port.
// Async active-low reset: control, counters and config return to defaults;
// row RAM is not cleared.
module eulerian_circuit_check_core #(
	parameter int MAX_VERTICES = ecc_pkg::MAX_VERTICES_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_write,
	input  logic [ecc_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [ecc_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [ecc_pkg::ROW_W-1:0]      row_bits,
	input  logic                           last_row,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [1:0]                     verdict
);

	ecc_pkg::cmd_t    cmd;
	ecc_pkg::status_t st;
	logic             in_fire;

	assign in_fire = in_valid && in_ready;

	ecc_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.last_row(last_row),
		.st      (st),
		.in_ready(in_ready),
		.cmd     (cmd)
	);

	ecc_datapath #(
		.MAX_VERTICES(MAX_VERTICES)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_write(cfg_write),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.in_fire  (in_fire),
		.row_bits (row_bits),
		.last_row (last_row),
		.out_ready(out_ready),
		.cmd      (cmd),
		.st       (st),
		.out_valid(out_valid),
		.verdict  (verdict)
	);

	a_busy_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire && last_row |=> !in_ready)
		else $error("input taken right after last row");

	a_verdict_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (verdict == ecc_pkg::VERDICT_NONE ||
			verdict == ecc_pkg::VERDICT_CIRCUIT || verdict == ecc_pkg::VERDICT_ISOLATED))
		else $error("bad verdict code");

	a_odd_gives_none: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load && st.odd |=> out_valid && verdict == ecc_pkg::VERDICT_NONE)
		else $error("odd degree not reported");

endmodule

// ===== rtl/core/ecc_ram.sv =====
module ecc_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 32
) (
	input  logic                                          clk,
	input  logic                                          we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                              wdata,
	input  logic                                          re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                              rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== rtl/core/ecc_ctrl.sv =====
module ecc_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	input  logic             last_row,
	input  ecc_pkg::status_t st,
	output logic             in_ready,
	output ecc_pkg::cmd_t    cmd
);

	typedef enum logic [7:0] {
		S_IDLE     = 8'b0000_0001,
		S_DEG_RD   = 8'b0000_0010,
		S_DEG_CHK  = 8'b0000_0100,
		S_CMP_RD   = 8'b0000_1000,
		S_CMP_LOAD = 8'b0001_0000,
		S_EXP_RD   = 8'b0010_0000,
		S_EXP_LOAD = 8'b0100_0000,
		S_FINISH   = 8'b1000_0000
	} state_t;

	state_t state_q, state_d;

	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			S_IDLE: begin
				if (in_valid && last_row) begin
					cmd.clear = 1'b1;
					state_d   = S_DEG_RD;
				end
			end
			S_DEG_RD: begin
				if (st.i_end) begin
					if (st.odd) begin
						state_d = S_FINISH;
					end else begin
						cmd.rewind = 1'b1;
						state_d    = S_CMP_RD;
					end
				end else begin
					cmd.rd_row = 1'b1;
					state_d    = S_DEG_CHK;
				end
			end
			S_DEG_CHK: begin
				cmd.deg_update = 1'b1;
				state_d        = S_DEG_RD;
			end
			S_CMP_RD: begin
				if (st.i_end) begin
					state_d = S_FINISH;
				end else begin
					cmd.rd_row = 1'b1;
					cmd.seed   = 1'b1;
					state_d    = S_CMP_LOAD;
				end
			end
			S_CMP_LOAD: begin
				cmd.reach_load = 1'b1;
				state_d        = S_EXP_RD;
			end
			S_EXP_RD: begin
				if (st.pending_none) begin
					cmd.close_comp = 1'b1;
					state_d        = S_CMP_RD;
				end else begin
					cmd.expand_rd = 1'b1;
					state_d       = S_EXP_LOAD;
				end
			end
			S_EXP_LOAD: begin
				cmd.reach_or = 1'b1;
				state_d      = S_EXP_RD;
			end
			S_FINISH: begin
				if (st.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// ===== rtl/core/ecc_datapath.sv =====
module ecc_datapath #(
	parameter int MAX_VERTICES = ecc_pkg::MAX_VERTICES_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_write,
	input  logic [ecc_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [ecc_pkg::CFG_DATA_W-1:0]    cfg_data,
	input  logic                              in_fire,
	input  logic [ecc_pkg::ROW_W-1:0]         row_bits,
	input  logic                              last_row,
	input  logic                              out_ready,
	input  ecc_pkg::cmd_t                     cmd,
	output ecc_pkg::status_t                  st,
	output logic                              out_valid,
	output logic [1:0]                        verdict
);

	localparam int IDX_W = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
	localparam int CNT_W = $clog2(MAX_VERTICES + 1);
	localparam int VCX_W = ecc_pkg::VC_W + 1;

	logic [ecc_pkg::VC_W-1:0] vertex_count_q;
	logic [ecc_pkg::SV_W-1:0] start_vertex_q;
	logic [CNT_W-1:0]         row_cnt_q;
	logic [CNT_W-1:0]         i_q;
	logic [CNT_W-1:0]         iso_cnt_q;
	logic [CNT_W-1:0]         comp_cnt_q;
	logic                     odd_q;
	logic [MAX_VERTICES-1:0]  iso_q;
	logic [MAX_VERTICES-1:0]  reached_q;
	logic [MAX_VERTICES-1:0]  reach_q;
	logic [MAX_VERTICES-1:0]  done_q;
	logic                     out_valid_q;
	logic [1:0]               verdict_q;

	logic [ecc_pkg::ROW_W-1:0] ram_rdata;
	logic                      wr_en;
	logic                      rd_en;
	logic [IDX_W-1:0]          rd_addr;
	logic [IDX_W-1:0]          k;
	logic [CNT_W-1:0]          n;
	logic [MAX_VERTICES-1:0]   m;
	logic [MAX_VERTICES-1:0]   upper;
	logic [MAX_VERTICES-1:0]   sel_i;
	logic [MAX_VERTICES-1:0]   sel_s;
	logic [MAX_VERTICES-1:0]   row_m;
	logic [MAX_VERTICES-1:0]   pending;
	logic [MAX_VERTICES-1:0]   k_onehot;
	logic [MAX_VERTICES-1:0]   marks;
	logic                      start_out;
	logic                      start_iso;
	logic [1:0]                verdict_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vertex_count_q <= ecc_pkg::VERTEX_COUNT_RST;
			start_vertex_q <= ecc_pkg::START_VERTEX_RST;
		end else if (cfg_write) begin
			case (cfg_index)
				ecc_pkg::REG_VERTEX_COUNT: vertex_count_q <= cfg_data;
				ecc_pkg::REG_START_VERTEX: start_vertex_q <= cfg_data[ecc_pkg::SV_W-1:0];
				default: ;
			endcase
		end
	end

	assign wr_en   = in_fire && (row_cnt_q < CNT_W'(MAX_VERTICES));
	assign rd_en   = cmd.rd_row || cmd.expand_rd;
	assign rd_addr = cmd.expand_rd ? k : i_q[IDX_W-1:0];

	ecc_ram #(
		.WIDTH(ecc_pkg::ROW_W),
		.DEPTH(MAX_VERTICES)
	) u_rows (
		.clk  (clk),
		.we   (wr_en),
		.waddr(row_cnt_q[IDX_W-1:0]),
		.wdata(row_bits),
		.re   (rd_en),
		.raddr(rd_addr),
		.rdata(ram_rdata)
	);

	always_comb begin
		if (VCX_W'(vertex_count_q) > VCX_W'(MAX_VERTICES)) begin
			n = CNT_W'(MAX_VERTICES);
		end else begin
			n = CNT_W'(vertex_count_q);
		end
	end

	always_comb begin
		for (int j = 0; j < MAX_VERTICES; j++) begin
			m[j]     = VCX_W'(j) < VCX_W'(n);
			upper[j] = CNT_W'(j) >= i_q;
			sel_i[j] = CNT_W'(j) == i_q;
			sel_s[j] = VCX_W'(j) == VCX_W'(start_vertex_q);
		end
	end

	assign row_m    = MAX_VERTICES'({{MAX_VERTICES{1'b0}}, ram_rdata}) & m;
	assign pending  = reach_q & ~done_q;
	assign k_onehot = pending & (~pending + MAX_VERTICES'(1));
	assign marks    = (reach_q | sel_i) & upper & ~reached_q;

	always_comb begin
		k = '0;
		for (int j = MAX_VERTICES - 1; j >= 0; j--) begin
			if (pending[j]) begin
				k = IDX_W'(j);
			end
		end
	end

	assign start_out = VCX_W'(start_vertex_q) >= VCX_W'(n);
	assign start_iso = |(iso_q & sel_s);

	always_comb begin
		if (odd_q) begin
			verdict_d = ecc_pkg::VERDICT_NONE;
		end else if ((CNT_W + 1)'(comp_cnt_q) > (CNT_W + 1)'(iso_cnt_q) + (CNT_W + 1)'(1)) begin
			verdict_d = ecc_pkg::VERDICT_NONE;
		end else if (start_out || start_iso) begin
			verdict_d = ecc_pkg::VERDICT_ISOLATED;
		end else begin
			verdict_d = ecc_pkg::VERDICT_CIRCUIT;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_cnt_q <= '0;
		end else if (in_fire) begin
			if (last_row) begin
				row_cnt_q <= '0;
			end else if (wr_en) begin
				row_cnt_q <= row_cnt_q + CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			i_q        <= '0;
			iso_cnt_q  <= '0;
			comp_cnt_q <= '0;
			odd_q      <= 1'b0;
			iso_q      <= '0;
			reached_q  <= '0;
		end else begin
			if (cmd.clear) begin
				i_q        <= '0;
				iso_cnt_q  <= '0;
				comp_cnt_q <= '0;
				odd_q      <= 1'b0;
				iso_q      <= '0;
				reached_q  <= '0;
			end
			if (cmd.rewind) begin
				i_q <= '0;
			end
			if (cmd.deg_update) begin
				i_q   <= i_q + CNT_W'(1);
				odd_q <= odd_q | (^row_m);
				if (~|row_m) begin
					iso_q     <= iso_q | sel_i;
					iso_cnt_q <= iso_cnt_q + CNT_W'(1);
				end
			end
			if (cmd.close_comp) begin
				i_q <= i_q + CNT_W'(1);
				if (|marks) begin
					reached_q  <= reached_q | marks;
					comp_cnt_q <= comp_cnt_q + CNT_W'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.seed) begin
			done_q <= sel_i;
		end else if (cmd.expand_rd) begin
			done_q <= done_q | k_onehot;
		end
		if (cmd.reach_load) begin
			reach_q <= row_m;
		end else if (cmd.reach_or) begin
			reach_q <= reach_q | row_m;
		end
	end

	// one-word output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			verdict_q <= verdict_d;
		end
	end

	assign st.i_end        = i_q >= n;
	assign st.odd          = odd_q;
	assign st.pending_none = ~|pending;
	assign st.out_free     = !out_valid_q || out_ready;

	assign out_valid = out_valid_q;
	assign verdict   = verdict_q;

endmodule

// ===== tb/tb_eulerian_circuit_check_core.sv =====
`timescale 1ns / 100ps

module tb_eulerian_circuit_check_core;

	localparam int MAXV           = ecc_pkg::MAX_VERTICES_DEF;
	localparam int SETTLE_CYCLES  = 2400;
	localparam int WATCHDOG_LIMIT = 20000;
	localparam int NUM_PHASES     = 12;
	localparam int PHASE_WORDS    = 166;

	typedef enum int {IDLE_NONE, IDLE_TX, IDLE_RX, IDLE_BOTH} idle_mode_t;
	typedef enum int {G_NOISE, G_EVEN_ROWS, G_CYCLES, G_TWO_RINGS, G_EMPTY} graph_kind_t;

	typedef struct {
		logic [ecc_pkg::ROW_W-1:0] row;
		logic                      last;
		bit                        hold;
	} row_word_t;

	logic                           clk       = 1'b0;
	logic                           arst_n    = 1'b0;
	logic                           cfg_write = 1'b0;
	logic [ecc_pkg::CFG_IDX_W-1:0]  cfg_index = ecc_pkg::REG_VERTEX_COUNT;
	logic [ecc_pkg::CFG_DATA_W-1:0] cfg_data  = '0;
	logic                           in_valid  = 1'b0;
	logic                           in_ready;
	logic [ecc_pkg::ROW_W-1:0]      row_bits  = '0;
	logic                           last_row  = 1'b0;
	logic                           out_valid;
	logic                           out_ready = 1'b0;
	logic [1:0]                     verdict;

	row_word_t   row_queue [$];
	logic [1:0]  verdict_queue [$];

	logic [ecc_pkg::ROW_W-1:0] adj_model [MAXV] = '{default: '0};
	int unsigned               row_idx_model    = 0;
	logic [ecc_pkg::VC_W-1:0]  vc_model         = ecc_pkg::VERTEX_COUNT_RST;
	logic [ecc_pkg::SV_W-1:0]  sv_model         = ecc_pkg::START_VERTEX_RST;

	int unsigned n_taken      = 0;
	int unsigned n_shown      = 0;
	int unsigned mismatches   = 0;
	int unsigned quiet_cycles = 0;
	int          tx_idle_pct  = 0;
	int          rx_stall_pct = 0;
	int          filled       = 0;

	int         ph_vc   [NUM_PHASES] = '{4, 8, 32, 5, 0, 63, 1, 6, 12, 3, 16, 33};
	int         ph_sv   [NUM_PHASES] = '{0, 3, 0, 2, 0, 31, 0, 9, 11, 1, 0, 17};
	idle_mode_t ph_mode [NUM_PHASES] = '{IDLE_NONE, IDLE_NONE, IDLE_TX, IDLE_RX, IDLE_BOTH,
		IDLE_NONE, IDLE_TX, IDLE_RX, IDLE_BOTH, IDLE_NONE, IDLE_TX, IDLE_RX};

	// {last, row}, vertex count 4
	logic [32:0] dir_words [27] = '{
		33'h0_0000000A, 33'h0_00000005, 33'h0_0000000A, 33'h1_00000005,
		33'h0_FFFFFFFF, 33'h0_FFFFFFFF, 33'h0_FFFFFFFF, 33'h1_FFFFFFFF,
		33'h0_00000001, 33'h0_00000000, 33'h0_00000000, 33'h1_00000000,
		33'h0_00000000, 33'h0_0000000C, 33'h0_0000000A, 33'h1_00000006,
		33'h0_00000003, 33'h0_00000003, 33'h0_0000000C, 33'h1_0000000C,
		33'h0_0000000A, 33'h0_00000005, 33'h0_0000000A, 33'h0_00000005,
		33'h0_DEADBEEF, 33'h1_12345678,
		33'h1_FFFFFFFA
	};

	eulerian_circuit_check_core u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.row_bits  (row_bits),
		.last_row  (last_row),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.verdict   (verdict)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic logic [1:0] predict_verdict();
		int unsigned n, comps, i, k;
		logic [ecc_pkg::ROW_W-1:0] m, iso, seen, reach, prev, marks, upper;
		bit odd;
		n     = (vc_model > MAXV) ? MAXV : vc_model;
		m     = (n >= ecc_pkg::ROW_W) ? '1 : ((32'd1 << n) - 32'd1);
		iso   = '0;
		seen  = '0;
		comps = 0;
		odd   = 1'b0;
		for (i = 0; i < n; i++) begin
			if ((adj_model[i] & m) == '0)
				iso[i] = 1'b1;
			if ($countones(adj_model[i] & m) % 2 != 0)
				odd = 1'b1;
		end
		if (odd)
			return ecc_pkg::VERDICT_NONE;
		for (i = 0; i < n; i++) begin
			reach = adj_model[i] & m;
			do begin
				prev = reach;
				for (k = 0; k < n; k++)
					if (reach[k])
						reach |= adj_model[k] & m;
			end while (reach != prev);
			upper = m & ~((32'd1 << i) - 32'd1);
			marks = (reach | (32'd1 << i)) & upper & ~seen;
			if (marks != '0) begin
				seen |= marks;
				comps++;
			end
		end
		if (comps > $countones(iso) + 1)
			return ecc_pkg::VERDICT_NONE;
		if (sv_model >= n || iso[sv_model])
			return ecc_pkg::VERDICT_ISOLATED;
		return ecc_pkg::VERDICT_CIRCUIT;
	endfunction

	task automatic report_mismatch(string what, logic [1:0] want, logic [1:0] got);
		$display("MISMATCH at %0t: %s, expected %0d got %0d", $realtime, what, want, got);
		mismatches++;
	endtask

	task automatic write_reg(logic [ecc_pkg::CFG_IDX_W-1:0] idx,
			logic [ecc_pkg::CFG_DATA_W-1:0] data);
		@(negedge clk);
		cfg_write = 1'b1;
		cfg_index = idx;
		cfg_data  = data;
		@(negedge clk);
		cfg_write = 1'b0;
		if (idx == ecc_pkg::REG_VERTEX_COUNT)
			vc_model = data;
		else
			sv_model = data[ecc_pkg::SV_W-1:0];
	endtask

	task automatic wait_idle();
		while (row_queue.size() != 0 || in_valid || verdict_queue.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// n: vertices in use, already saturated
	task automatic queue_matrix(int n, bit hold, ref int queued);
		logic [ecc_pkg::ROW_W-1:0] mat [40];
		logic [ecc_pkg::ROW_W-1:0] m;
		int perm [32];
		int cnt, rows, t, j, tmp, a, b, c, x, skip, cycles, len, base, roll;
		graph_kind_t kind;
		m    = (n >= ecc_pkg::ROW_W) ? '1 : ((32'd1 << n) - 32'd1);
		roll = $urandom_range(0, 9);
		kind = (roll < 2) ? G_NOISE : (roll < 4) ? G_EVEN_ROWS : (roll < 8) ? G_CYCLES :
			(roll == 8) ? G_TWO_RINGS : G_EMPTY;
		for (t = 0; t < 40; t++)
			mat[t] = (t >= MAXV) ? $urandom : '0;
		skip = ($urandom_range(0, 3) == 0) ? int'(sv_model) : -1;
		cnt  = 0;
		for (t = 0; t < n; t++)
			if (t != skip) begin
				perm[cnt] = t;
				cnt++;
			end
		for (t = cnt; t > 1; t--) begin
			j         = $urandom_range(0, t - 1);
			tmp       = perm[t-1];
			perm[t-1] = perm[j];
			perm[j]   = tmp;
		end
		cycles = 0;
		case (kind)
			G_NOISE: begin
				for (t = 0; t < 40; t++)
					mat[t] = $urandom;
			end
			G_EVEN_ROWS: begin
				for (t = 0; t < n; t++) begin
					mat[t] = ($urandom_range(0, 1) != 0) ? $urandom : ($urandom & $urandom);
					if ($countones(mat[t] & m) % 2 != 0)
						mat[t][$urandom_range(0, n - 1)] ^= 1'b1;
				end
			end
			G_CYCLES:    cycles = (cnt >= 3) ? $urandom_range(1, 3) : 0;
			G_TWO_RINGS: cycles = (cnt >= 6) ? 2 : 0;
			default: ;
		endcase
		for (c = 0; c < cycles; c++) begin
			if (kind == G_TWO_RINGS) begin
				base = 3 * c;
				len  = 3;
			end else begin
				base = $urandom_range(0, cnt - 1);
				len  = $urandom_range(3, (cnt < 6) ? cnt : 6);
			end
			for (x = 0; x < len; x++) begin
				a = perm[(base + x) % cnt];
				b = perm[(base + (x + 1) % len) % cnt];
				mat[a][b] ^= 1'b1;
				mat[b][a] ^= 1'b1;
			end
		end
		if ($urandom_range(0, 1) != 0)
			for (t = 0; t < 40; t++)
				mat[t] |= $urandom & ~m;
		roll = $urandom_range(0, 99);
		if (roll < 8)
			rows = $urandom_range(1, n + 4);
		else if (roll < 11)
			rows = $urandom_range(33, 36);
		else
			rows = (n == 0) ? $urandom_range(1, 3) : n;
		// never let the block read a row that has not been written since reset
		if (rows < n && filled < n)
			rows = n;
		if (rows > filled)
			filled = (rows > MAXV) ? MAXV : rows;
		for (t = 0; t < rows; t++)
			row_queue.push_back('{row: mat[t], last: (t == rows - 1), hold: (hold && t == 0)});
		queued += rows;
	endtask

	always @(negedge clk) begin : driver
		row_word_t word;
		out_ready <= ($urandom_range(0, 99) >= rx_stall_pct);
		if (!in_valid || n_taken == n_shown) begin
			if (arst_n && row_queue.size() != 0
					&& !(row_queue[0].hold && verdict_queue.size() != 0)
					&& $urandom_range(0, 99) >= tx_idle_pct) begin
				word = row_queue.pop_front();
				in_valid <= 1'b1;
				row_bits <= word.row;
				last_row <= word.last;
				n_shown++;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin : monitor
		logic [1:0] want;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (verdict_queue.size() == 0) begin
					report_mismatch("verdict word with none expected", 2'bxx, verdict);
				end else begin
					want = verdict_queue.pop_front();
					if (verdict !== want)
						report_mismatch("verdict", want, verdict);
				end
			end
			if (in_valid && in_ready) begin
				n_taken++;
				if (row_idx_model < MAXV) begin
					adj_model[row_idx_model] = row_bits;
					row_idx_model++;
				end
				if (last_row) begin
					verdict_queue.push_back(predict_verdict());
					row_idx_model = 0;
				end
			end
		end
	end

	always @(posedge clk) begin : watchdog
		if ((in_valid && in_ready) || (out_valid && out_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	initial begin
		int p, t, queued, n;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		for (p = 0; p < NUM_PHASES; p++) begin
			if (p != 0)
				wait_idle();
			tx_idle_pct  = (ph_mode[p] == IDLE_TX) ? 85 : (ph_mode[p] == IDLE_BOTH) ? 31 : 0;
			rx_stall_pct = (ph_mode[p] == IDLE_RX) ? 85 : (ph_mode[p] == IDLE_BOTH) ? 31 : 0;
			write_reg(ecc_pkg::REG_VERTEX_COUNT, ecc_pkg::CFG_DATA_W'(ph_vc[p]));
			write_reg(ecc_pkg::REG_START_VERTEX, {1'($urandom_range(0, 1)), 5'(ph_sv[p])});
			if (p == 0) begin
				for (t = 0; t < 27; t++)
					row_queue.push_back('{row: dir_words[t][31:0], last: dir_words[t][32],
						hold: 1'b0});
				filled = 6;
			end else begin
				n      = (ph_vc[p] > MAXV) ? MAXV : ph_vc[p];
				queued = 0;
				while (queued < PHASE_WORDS)
					queue_matrix(n, (p == 1 && queued == 0) || $urandom_range(0, 29) == 0,
						queued);
			end
		end
		wait_idle();
		if (mismatches == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

// ===== filelist.f =====
rtl/core/ecc_pkg.sv
rtl/core/ecc_ram.sv
rtl/core/ecc_ctrl.sv
rtl/core/ecc_datapath.sv
rtl/core/eulerian_circuit_check_core.sv
tb/tb_eulerian_circuit_check_core.sv
